// File: sv/sknot_pkg.sv
// Shared types, codes and sizes for the spline knot table segment search block.
package sknot_pkg;

	localparam int MAX_NODES = 256;
	localparam int IDX_W     = $clog2(MAX_NODES);
	localparam int CNT_W     = IDX_W + 1;
	localparam int WIDE_W    = CNT_W + 9;
	localparam int SEG_W     = 8;
	localparam int CNT_OUT_W = 9;

	localparam logic [IDX_W-1:0] TOP_BIT = IDX_W'(1) << (IDX_W - 1);

	localparam logic [1:0] FUNC_CLEAR  = 2'd0;
	localparam logic [1:0] FUNC_APPEND = 2'd1;

	localparam logic [2:0] ST_APPENDED  = 3'd0;
	localparam logic [2:0] ST_NOT_AFTER = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_CLEARED   = 3'd3;
	localparam logic [2:0] ST_INSIDE    = 3'd4;
	localparam logic [2:0] ST_BEFORE    = 3'd5;
	localparam logic [2:0] ST_AFTER     = 3'd6;
	localparam logic [2:0] ST_EMPTY     = 3'd7;

	typedef struct packed {
		logic [15:0]        x;
		logic [15:0]        y;
		logic signed [15:0] angle;
	} node_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_GUESS,
		S_SEARCH,
		S_NODE
	} state_t;

	typedef struct packed {
		logic accept;
		logic guess_chk;
		logic search_step;
		logic node_load;
	} cmd_t;

	typedef struct packed {
		logic finish_now;
		logic to_guess;
		logic guess_hit;
		logic search_last;
	} stat_t;

endpackage

// File: sv/sknot_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sknot_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: sv/sknot_dp.sv
// Datapath: knot storage, classification, guess check, bitwise search and result registers.
module sknot_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sknot_pkg::cmd_t       cmd,
	output sknot_pkg::stat_t      stat,
	input  logic [1:0]            func,
	input  logic [15:0]           x_grain,
	input  logic [15:0]           y_rung,
	input  logic signed [15:0]    node_angle,
	input  logic [7:0]            seg_hint,
	output logic [2:0]            status,
	output logic [7:0]            segment_index,
	output logic                  guess_hit,
	output logic [8:0]            node_count,
	output logic [15:0]           start_x,
	output logic [15:0]           end_x,
	output logic [15:0]           start_y,
	output logic [15:0]           end_y,
	output logic signed [15:0]    start_angle,
	output logic signed [15:0]    end_angle
);
	import sknot_pkg::*;

	logic [CNT_W-1:0] count_q, count_d, cnt_m1;
	logic [15:0]      first_x_q, last_x_q, q_q;
	logic [IDX_W-1:0] g_q, gidx, last_idx;
	logic             guess_ok_q, guess_ok_in;
	logic [2:0]       lk_status_q;
	logic [IDX_W-1:0] pos_q, cand_q, bit_q, seg_q;
	logic             cand_ok_q, hit_q;
	logic [IDX_W-1:0] newpos, next_bit, next_cand;
	logic             take, hit;
	logic             is_lookup, empty, below_first, after, full, not_after, wr_en;
	logic [IDX_W-1:0] addr_a, addr_b;
	logic [$bits(node_t)-1:0] rd_a_raw, rd_b_raw;
	node_t            rd_a, rd_b, wnode;
	logic [2:0]       imm_status;

	logic [2:0]           status_q;
	logic [SEG_W-1:0]     seg_out_q;
	logic                 hit_out_q;
	logic [CNT_OUT_W-1:0] count_out_q;
	node_t                start_q, end_q;

	assign wnode = '{x: x_grain, y: y_rung, angle: node_angle};
	assign rd_a  = node_t'(rd_a_raw);
	assign rd_b  = node_t'(rd_b_raw);

	// Two copies of the table give two read ports for the segment's end nodes.
	sknot_ram #(.WIDTH($bits(node_t)), .DEPTH(MAX_NODES)) u_ram_a (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (wnode),
		.raddr (addr_a),
		.rdata (rd_a_raw)
	);

	sknot_ram #(.WIDTH($bits(node_t)), .DEPTH(MAX_NODES)) u_ram_b (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (wnode),
		.raddr (addr_b),
		.rdata (rd_b_raw)
	);

	// Classification of the item on the input channel.
	assign cnt_m1      = count_q - CNT_W'(1);
	assign last_idx    = cnt_m1[IDX_W-1:0];
	assign is_lookup   = func[1];
	assign empty       = (count_q == '0);
	assign below_first = (x_grain < first_x_q);
	assign after       = (x_grain >= last_x_q);
	assign full        = (count_q == CNT_W'(MAX_NODES));
	assign not_after   = !empty && (x_grain <= last_x_q);
	assign gidx        = IDX_W'(seg_hint);
	assign guess_ok_in = (WIDE_W'(seg_hint) + WIDE_W'(1)) < WIDE_W'(count_q);
	assign wr_en       = cmd.accept && (func == FUNC_APPEND) && !full && !not_after;

	assign stat.finish_now = !is_lookup || empty;
	assign stat.to_guess   = is_lookup && !empty && !below_first && !after;

	// Guess segment check, bounds inclusive.
	assign hit = guess_ok_q && (rd_a.x <= q_q) && (q_q <= rd_b.x);
	assign stat.guess_hit = hit;

	// One bit of the last-knot-not-above-query index per step, MSB first.
	assign take      = cand_ok_q && (rd_a.x <= q_q);
	assign newpos    = take ? cand_q : pos_q;
	assign next_bit  = bit_q >> 1;
	assign next_cand = newpos | next_bit;
	assign stat.search_last = bit_q[0];

	always_comb begin
		addr_a = '0;
		addr_b = '0;
		if (cmd.accept) begin
			if (below_first) begin
				addr_a = '0;
				addr_b = '0;
			end else if (after) begin
				addr_a = last_idx;
				addr_b = last_idx;
			end else begin
				addr_a = gidx;
				addr_b = gidx + IDX_W'(1);
			end
		end else if (cmd.guess_chk) begin
			if (hit) begin
				addr_a = g_q;
				addr_b = g_q + IDX_W'(1);
			end else begin
				addr_a = TOP_BIT;
			end
		end else if (cmd.search_step) begin
			if (bit_q[0]) begin
				addr_a = newpos;
				addr_b = newpos + IDX_W'(1);
			end else begin
				addr_a = next_cand;
			end
		end
	end

	always_comb begin
		count_d    = count_q;
		imm_status = ST_EMPTY;
		case (func)
			FUNC_CLEAR: begin
				count_d    = '0;
				imm_status = ST_CLEARED;
			end
			FUNC_APPEND: begin
				if (full) begin
					imm_status = ST_FULL;
				end else if (not_after) begin
					imm_status = ST_NOT_AFTER;
				end else begin
					count_d    = count_q + CNT_W'(1);
					imm_status = ST_APPENDED;
				end
			end
			default: imm_status = ST_EMPTY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.accept) begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			last_x_q <= x_grain;
			if (empty) begin
				first_x_q <= x_grain;
			end
		end
		if (cmd.accept) begin
			q_q         <= x_grain;
			g_q         <= gidx;
			guess_ok_q  <= guess_ok_in;
			lk_status_q <= below_first ? ST_BEFORE : (after ? ST_AFTER : ST_INSIDE);
			if (stat.finish_now) begin
				status_q    <= imm_status;
				seg_out_q   <= '0;
				hit_out_q   <= 1'b0;
				count_out_q <= CNT_OUT_W'(count_d);
				start_q     <= '0;
				end_q       <= '0;
			end
		end
		if (cmd.guess_chk) begin
			pos_q     <= '0;
			bit_q     <= TOP_BIT;
			cand_q    <= TOP_BIT;
			cand_ok_q <= CNT_W'(TOP_BIT) < count_q;
			hit_q     <= hit;
			seg_q     <= g_q;
		end
		if (cmd.search_step) begin
			pos_q     <= newpos;
			bit_q     <= next_bit;
			cand_q    <= next_cand;
			cand_ok_q <= CNT_W'(next_cand) < count_q;
			seg_q     <= newpos;
		end
		if (cmd.node_load) begin
			status_q    <= lk_status_q;
			seg_out_q   <= (lk_status_q == ST_INSIDE) ? SEG_W'(seg_q) : '0;
			hit_out_q   <= (lk_status_q == ST_INSIDE) && hit_q;
			count_out_q <= CNT_OUT_W'(count_q);
			start_q     <= rd_a;
			end_q       <= rd_b;
		end
	end

	assign status        = status_q;
	assign segment_index = seg_out_q;
	assign guess_hit     = hit_out_q;
	assign node_count    = count_out_q;
	assign start_x       = start_q.x;
	assign end_x         = end_q.x;
	assign start_y       = start_q.y;
	assign end_y         = end_q.y;
	assign start_angle   = start_q.angle;
	assign end_angle     = end_q.angle;

endmodule

// File: sv/sknot_ctrl.sv
// Controller: sequences accept, guess check, search steps and node fetch; owns output valid.
module sknot_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  sknot_pkg::stat_t stat,
	output sknot_pkg::cmd_t  cmd
);
	import sknot_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_set;
	logic   ready;

	// One item in flight; the result slot must be free or draining.
	assign ready     = (state_q == S_IDLE) && (!out_valid_q || !out_stall);
	assign in_stall  = !ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_set) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		out_set = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && ready) begin
					cmd.accept = 1'b1;
					if (stat.finish_now) begin
						out_set = 1'b1;
					end else if (stat.to_guess) begin
						state_d = S_GUESS;
					end else begin
						state_d = S_NODE;
					end
				end
			end
			S_GUESS: begin
				cmd.guess_chk = 1'b1;
				state_d = stat.guess_hit ? S_NODE : S_SEARCH;
			end
			S_SEARCH: begin
				cmd.search_step = 1'b1;
				if (stat.search_last) begin
					state_d = S_NODE;
				end
			end
			S_NODE: begin
				cmd.node_load = 1'b1;
				out_set = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// File: sv/spline_knot_table_segment_search.sv
// Top level of the sorted spline knot table with segment search.
// Input channel (in_valid/in_stall) carries one command item: clear, append
// a knot, or look up the segment that holds x_grain. Output channel
// (out_valid/out_stall) returns exactly one result item per command.
// Clear, append and lookup on an empty table finish at the accepting edge:
// the result is valid the next cycle.
// Lookup before the first or at/after the last knot goes from accept to
// the node fetch (one node read from the knot RAM). Inside the table a
// guess hit passes the guess check to the node fetch; a miss adds one
// search step per index bit (8 at 256 knots). The single read port per
// RAM copy and the serial search over index bits set the lookup length.
// One item is worked on at a time; in_stall stays high until the block is
// idle and its result register is free or being drained.
// A stalled result holds its value; the next item waits behind it.
// Reset empties the table (count zero) and drops any pending result; knot
// contents are not cleared and are never used before being written.
module spline_knot_table_segment_search (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           func,
	input  logic [15:0]          x_grain,
	input  logic [15:0]          y_rung,
	input  logic signed [15:0]   node_angle,
	input  logic [7:0]           seg_hint,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [2:0]           status,
	output logic [7:0]           segment_index,
	output logic                 guess_hit,
	output logic [8:0]           node_count,
	output logic [15:0]          start_x,
	output logic [15:0]          end_x,
	output logic [15:0]          start_y,
	output logic [15:0]          end_y,
	output logic signed [15:0]   start_angle,
	output logic signed [15:0]   end_angle
);
	import sknot_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	sknot_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	sknot_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.func          (func),
		.x_grain       (x_grain),
		.y_rung        (y_rung),
		.node_angle    (node_angle),
		.seg_hint      (seg_hint),
		.status        (status),
		.segment_index (segment_index),
		.guess_hit     (guess_hit),
		.node_count    (node_count),
		.start_x       (start_x),
		.end_x         (end_x),
		.start_y       (start_y),
		.end_y         (end_y),
		.start_angle   (start_angle),
		.end_angle     (end_angle)
	);

	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && func == FUNC_CLEAR)
		|=> (out_valid && status == ST_CLEARED && node_count == '0))
		else $error("clear did not produce an empty-table result");

	a_inside_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_INSIDE) |-> (start_x < end_x))
		else $error("segment end nodes out of order");

	a_edge_same_node: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_BEFORE || status == ST_AFTER))
		|-> (start_x == end_x && start_y == end_y && start_angle == end_angle))
		else $error("edge result reports two different knots");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (int'(node_count) <= MAX_NODES))
		else $error("knot count beyond table size");

endmodule
